// ===== hw/rtl/aepd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aepd_pkg
// Types, codes and constants shared by the angle sensor poller and decoder.
// ----------------------------------------------------------------------------
package aepd_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_A     = 2'd1,
    MODE_B     = 2'd2,
    MODE_INERT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_INTERVAL = 3'd1,
    CFG_OFFSET   = 3'd2,
    CFG_SCALE    = 3'd3,
    CFG_ADDRESS  = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [7:0]  RegStartA   = 8'hFA;
  localparam logic [7:0]  RegStartB   = 8'h0B;
  localparam logic [2:0]  LenA        = 3'd6;
  localparam logic [2:0]  LenB        = 3'd3;
  localparam logic [31:0] HoldoffMs   = 32'd10;
  localparam logic [15:0] MinInterval = 16'd5;

  localparam logic [1:0]  RstMode     = MODE_OFF;
  localparam logic [15:0] RstInterval = 16'd10;
  localparam logic [15:0] RstOffset   = 16'd0;
  localparam logic [31:0] RstScale    = 32'h0001_0000;
  localparam logic [6:0]  RstAddress  = 7'd64;

  typedef struct packed {
    logic [1:0]  sensor_mode;
    logic [15:0] poll_interval_ms;
    logic [15:0] angle_offset;
    logic [31:0] position_scale_q16;
    logic [6:0]  device_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] uptime_ms;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
  } item_t;

  typedef struct packed {
    logic        read_request;
    logic [6:0]  request_address;
    logic [7:0]  start_register;
    logic [2:0]  read_length;
    logic [15:0] angle_raw;
    logic        angle_valid;
    logic [7:0]  gain_level;
    logic [7:0]  diag_bits;
    logic [15:0] field_magnitude;
    logic [31:0] error_total;
    logic [31:0] position_q16;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/aepd_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aepd_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module aepd_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire aepd_pkg::item_t in_data_i,
  input  wire logic           advance_i,
  output logic                valid_o,
  output aepd_pkg::item_t     data_o
);
  import aepd_pkg::*;

  logic  valid_q, valid_d;
  item_t data_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/aepd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aepd_core
// Poll scheduler and read decoder: holds the sensor state, updates it once
// per beat and forms the result from the updated state.
// ----------------------------------------------------------------------------
module aepd_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire aepd_pkg::item_t  item_i,
  input  wire aepd_pkg::cfg_t   cfg_i,
  output aepd_pkg::result_t     result_o
);
  import aepd_pkg::*;

  logic [15:0] tick_q, tick_d;
  logic [15:0] angle_q, angle_d;
  logic        valid_q, valid_d;
  logic [7:0]  gain_q, gain_d;
  logic [7:0]  diag_q, diag_d;
  logic [15:0] mag_q, mag_d;
  logic [31:0] err_q, err_d;
  logic [31:0] pos_q, pos_d;

  logic               sensor;
  logic               hold;
  logic [15:0]        thr;
  logic [15:0]        tick_inc;
  logic               req;
  logic [15:0]        sum;
  logic signed [47:0] prod;

  assign sensor   = (mode_e'(cfg_i.sensor_mode) == MODE_A) ||
                    (mode_e'(cfg_i.sensor_mode) == MODE_B);
  assign hold     = !valid_q && (item_i.uptime_ms < HoldoffMs);
  assign thr      = (cfg_i.poll_interval_ms > MinInterval) ? cfg_i.poll_interval_ms
                                                           : MinInterval;
  assign tick_inc = tick_q + 16'd1;
  assign sum      = angle_d + cfg_i.angle_offset;
  assign prod     = $signed(sum) * $signed(cfg_i.position_scale_q16);
  assign pos_d    = sensor ? prod[47:16] : pos_q;

  always_comb begin
    tick_d  = tick_q;
    angle_d = angle_q;
    valid_d = valid_q;
    gain_d  = gain_q;
    diag_d  = diag_q;
    mag_d   = mag_q;
    err_d   = err_q;
    req     = 1'b0;
    if (mode_e'(cfg_i.sensor_mode) == MODE_OFF) begin
      if (kind_e'(item_i.kind) == KIND_TICK) begin
        valid_d = 1'b0;
      end
    end else if (sensor) begin
      unique case (kind_e'(item_i.kind))
        KIND_TICK: begin
          if (!hold) begin
            if (tick_inc >= thr) begin
              tick_d = '0;
              req    = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        KIND_READ: begin
          if (mode_e'(cfg_i.sensor_mode) == MODE_A) begin
            angle_d = {item_i.byte4, item_i.byte5};
            gain_d  = item_i.byte0;
            diag_d  = item_i.byte1;
            mag_d   = {item_i.byte2, item_i.byte3};
          end else begin
            angle_d = {item_i.byte1[3:0], item_i.byte2, 4'd0};
            gain_d  = '0;
            diag_d  = item_i.byte0;
            mag_d   = '0;
          end
          valid_d = 1'b1;
        end
        KIND_ERROR: begin
          err_d = err_q + 32'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      angle_q <= '0;
      valid_q <= 1'b0;
      gain_q  <= '0;
      diag_q  <= '0;
      mag_q   <= '0;
      err_q   <= '0;
      pos_q   <= '0;
    end else if (advance_i) begin
      tick_q  <= tick_d;
      angle_q <= angle_d;
      valid_q <= valid_d;
      gain_q  <= gain_d;
      diag_q  <= diag_d;
      mag_q   <= mag_d;
      err_q   <= err_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    result_o.read_request    = req;
    result_o.request_address = req ? cfg_i.device_address : 7'd0;
    result_o.start_register  = '0;
    result_o.read_length     = '0;
    if (req) begin
      if (mode_e'(cfg_i.sensor_mode) == MODE_A) begin
        result_o.start_register = RegStartA;
        result_o.read_length    = LenA;
      end else begin
        result_o.start_register = RegStartB;
        result_o.read_length    = LenB;
      end
    end
    result_o.angle_raw       = angle_d;
    result_o.angle_valid     = valid_d;
    result_o.gain_level      = gain_d;
    result_o.diag_bits       = diag_d;
    result_o.field_magnitude = mag_d;
    result_o.error_total     = err_d;
    result_o.position_q16    = pos_d;
  end

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(err_q) && $stable(tick_q) && $stable(angle_q))
    else $error("state changed without a beat");

  a_err_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |=> (err_q == $past(err_q)) || (err_q == $past(err_q) + 32'd1))
    else $error("error count jumped");

  a_req_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> sensor && (tick_d == 16'd0) &&
            ((result_o.read_length == LenA) || (result_o.read_length == LenB)))
    else $error("read request outside sensor mode");

  a_tick_below_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && sensor && (tick_q < thr) |=> (tick_q <= $past(thr)))
    else $error("tick counter passed threshold");

endmodule
`default_nettype wire

// ===== hw/rtl/aepd_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aepd_out_stage
// Result register: holds one beat until the consumer takes it.
// ----------------------------------------------------------------------------
module aepd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire aepd_pkg::result_t result_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output aepd_pkg::result_t      out_data_o
);
  import aepd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/abs_encoder_poll_and_decode.sv =====
`default_nettype none
// Accepted beats pass the input register, the core logic and the result register.
// Throughput: one beat per cycle; a stalled result holds the input register,
// so one more beat is taken and then input ready drops until the result moves.
// Rate is set by the combinational state update and 16x32 multiply.
// Reset: control and sensor state clear, config registers take their reset values.
// ----------------------------------------------------------------------------
// abs_encoder_poll_and_decode
// Absolute angle sensor poll scheduler and read decoder with config registers.
// ----------------------------------------------------------------------------
module abs_encoder_poll_and_decode (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [aepd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [aepd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire aepd_pkg::item_t              in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output aepd_pkg::result_t                 out_data_o
);
  import aepd_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    item_valid;
  item_t   item;
  logic    out_ready;
  logic    advance;
  result_t result;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:     cfg_d.sensor_mode        = cfg_wdata_i[1:0];
        CFG_INTERVAL: cfg_d.poll_interval_ms   = cfg_wdata_i[15:0];
        CFG_OFFSET:   cfg_d.angle_offset       = cfg_wdata_i[15:0];
        CFG_SCALE:    cfg_d.position_scale_q16 = cfg_wdata_i[31:0];
        CFG_ADDRESS:  cfg_d.device_address     = cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_mode        <= RstMode;
      cfg_q.poll_interval_ms   <= RstInterval;
      cfg_q.angle_offset       <= RstOffset;
      cfg_q.position_scale_q16 <= RstScale;
      cfg_q.device_address     <= RstAddress;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance = item_valid && out_ready;

  aepd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  aepd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  aepd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the angle sensor poller and decoder. A behavioral
// copy of the poll scheduler and read decoder predicts every result beat;
// directed tests exercise each mode and corner, then random phases mix
// settings, item kinds and flow-control gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import aepd_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;

  abs_encoder_poll_and_decode u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // settings and sensor state of the behavioral copy
  mode_e       mode_q;
  logic [15:0] interval_q;
  logic [15:0] offset_q;
  logic [31:0] scale_q;
  logic [6:0]  address_q;
  logic [15:0] tick_q;
  logic [15:0] angle_q;
  logic        valid_q;
  logic [7:0]  gain_q;
  logic [7:0]  diag_q;
  logic [15:0] magnitude_q;
  logic [31:0] errors_q;
  logic [31:0] position_q;

  result_t     expected_readouts[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          steady_flow = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] scaled_position(logic [15:0] ang, logic [15:0] off,
                                                  logic [31:0] scale);
    logic [15:0] sum;
    logic signed [63:0] prod;
    sum = ang + off;
    prod = $signed(sum) * $signed(scale);
    return prod[47:16];
  endfunction

  function automatic item_t item_of(logic [1:0] kind, logic [31:0] uptime,
                                    logic [47:0] bytes);
    item_t it;
    it.kind = kind;
    it.uptime_ms = uptime;
    {it.byte0, it.byte1, it.byte2, it.byte3, it.byte4, it.byte5} = bytes;
    return it;
  endfunction

  task automatic reset_decoder_model();
    mode_q = MODE_OFF;
    interval_q = RstInterval;
    offset_q = RstOffset;
    scale_q = RstScale;
    address_q = RstAddress;
    tick_q = '0;
    angle_q = '0;
    valid_q = 1'b0;
    gain_q = '0;
    diag_q = '0;
    magnitude_q = '0;
    errors_q = '0;
    position_q = '0;
  endtask

  task automatic update_decoder_model(input item_t it);
    result_t r;
    logic [15:0] threshold;
    r = '0;
    case (mode_q)
      MODE_OFF: begin
        if (it.kind == KIND_TICK) valid_q = 1'b0;
      end
      MODE_A, MODE_B: begin
        if (it.kind == KIND_TICK) begin
          if (valid_q || it.uptime_ms >= HoldoffMs) begin
            threshold = (interval_q > MinInterval) ? interval_q : MinInterval;
            tick_q = tick_q + 16'd1;
            if (tick_q >= threshold) begin
              tick_q = '0;
              r.read_request = 1'b1;
              r.request_address = address_q;
              r.start_register = (mode_q == MODE_A) ? RegStartA : RegStartB;
              r.read_length = (mode_q == MODE_A) ? LenA : LenB;
            end
          end
        end else if (it.kind == KIND_READ) begin
          if (mode_q == MODE_A) begin
            angle_q = {it.byte4, it.byte5};
            gain_q = it.byte0;
            diag_q = it.byte1;
            magnitude_q = {it.byte2, it.byte3};
          end else begin
            angle_q = {it.byte1[3:0], it.byte2, 4'h0};
            gain_q = '0;
            diag_q = it.byte0;
            magnitude_q = '0;
          end
          valid_q = 1'b1;
        end else if (it.kind == KIND_ERROR) begin
          errors_q = errors_q + 32'd1;
        end
        position_q = scaled_position(angle_q, offset_q, scale_q);
      end
      default: ;
    endcase
    r.angle_raw = angle_q;
    r.angle_valid = valid_q;
    r.gain_level = gain_q;
    r.diag_bits = diag_q;
    r.field_magnitude = magnitude_q;
    r.error_total = errors_q;
    r.position_q16 = position_q;
    expected_readouts.push_back(r);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:     mode_q = mode_e'(data[1:0]);
      CFG_INTERVAL: interval_q = data[15:0];
      CFG_OFFSET:   offset_q = data[15:0];
      CFG_SCALE:    scale_q = data;
      CFG_ADDRESS:  address_q = data[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid stays high after the beat; the next send or drain drops or reuses it
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    update_decoder_model(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readouts.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_readouts.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        e = expected_readouts.pop_front();
        compare_field("read_request", 32'(e.read_request), 32'(out_data.read_request));
        compare_field("request_address", 32'(e.request_address),
                      32'(out_data.request_address));
        compare_field("start_register", 32'(e.start_register),
                      32'(out_data.start_register));
        compare_field("read_length", 32'(e.read_length), 32'(out_data.read_length));
        compare_field("angle_raw", 32'(e.angle_raw), 32'(out_data.angle_raw));
        compare_field("angle_valid", 32'(e.angle_valid), 32'(out_data.angle_valid));
        compare_field("gain_level", 32'(e.gain_level), 32'(out_data.gain_level));
        compare_field("diag_bits", 32'(e.diag_bits), 32'(out_data.diag_bits));
        compare_field("field_magnitude", 32'(e.field_magnitude),
                      32'(out_data.field_magnitude));
        compare_field("error_total", e.error_total, out_data.error_total);
        compare_field("position_q16", e.position_q16, out_data.position_q16);
      end
    end
  end

  initial begin
    int unsigned stall;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_disabled_after_reset();
    send_item(item_of(KIND_TICK, 32'd100, 48'h0));
    send_item(item_of(KIND_READ, 32'd200, 48'hFFFF_FFFF_FFFF));
    send_item(item_of(KIND_ERROR, 32'd300, 48'h0));
    send_item(item_of(KindUnused, 32'd400, 48'h0));
    drain();
  endtask

  task automatic test_startup_holdoff();
    cfg_write(CFG_INTERVAL, 32'd0);
    cfg_write(CFG_ADDRESS, 32'h7F);
    cfg_write(CFG_MODE, 32'(MODE_A));
    send_item(item_of(KIND_TICK, 32'd0, 48'h0));
    send_item(item_of(KIND_TICK, 32'd9, 48'h0));
    for (int i = 0; i < 5; i++) begin
      send_item(item_of(KIND_TICK, 32'd10 + i, 48'h0));
    end
    drain();
  endtask

  task automatic test_decode_type_a();
    cfg_write(CFG_SCALE, 32'h7FFF_FFFF);
    cfg_write(CFG_OFFSET, 32'h7FFF);
    send_item(item_of(KIND_READ, 32'd20, 48'hFFFF_FFFF_FFFF));
    send_item(item_of(KIND_READ, 32'd21, 48'h0));
    send_item(item_of(KIND_ERROR, 32'd22, 48'h0));
    drain();
    cfg_write(CFG_SCALE, 32'h8000_0000);
    cfg_write(CFG_OFFSET, 32'h8000);
    cfg_write(CFG_ADDRESS, 32'h0);
    send_item(item_of(KindUnused, 32'd23, 48'h0));
    drain();
  endtask

  task automatic test_decode_type_b();
    cfg_write(CFG_MODE, 32'(MODE_B));
    send_item(item_of(KIND_READ, 32'd30, 48'hFFFF_FFFF_FFFF));
    send_item(item_of(KIND_READ, 32'd31, 48'h5AC3_9612_3456));
    drain();
  endtask

  task automatic test_lowered_interval();
    cfg_write(CFG_INTERVAL, 32'hFFFF);
    repeat (5) send_item(item_of(KIND_TICK, 32'hFFFF_FFFF, 48'h0));
    drain();
    cfg_write(CFG_INTERVAL, 32'd3);
    send_item(item_of(KIND_TICK, 32'hFFFF_FFFF, 48'h0));
    drain();
  endtask

  task automatic test_inert_mode();
    cfg_write(CFG_MODE, 32'(MODE_INERT));
    cfg_write(CFG_SCALE, 32'h0001_0000);
    send_item(item_of(KIND_TICK, 32'd50, 48'h0));
    send_item(item_of(KIND_READ, 32'd51, 48'h1234_5678_9ABC));
    drain();
  endtask

  task automatic test_disabled_clears_valid();
    cfg_write(CFG_MODE, 32'(MODE_OFF));
    send_item(item_of(KIND_READ, 32'd60, 48'hA5A5_A5A5_A5A5));
    send_item(item_of(KIND_TICK, 32'd61, 48'h0));
    drain();
  endtask

  task automatic randomize_settings();
    int unsigned r;
    logic [31:0] scale_picks[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                    32'hFFFF_FFFF, 32'h0001_0000};
    logic [15:0] offset_picks[4] = '{16'h8000, 16'h7FFF, 16'h0, 16'hFFFF};
    r = $urandom_range(0, 99);
    if (r < 70) cfg_write(CFG_INTERVAL, $urandom_range(0, 12));
    else if (r < 85) cfg_write(CFG_INTERVAL, 32'hFFFF);
    else cfg_write(CFG_INTERVAL, $urandom & 32'hFFFF);
    if ($urandom_range(0, 4) == 0)
      cfg_write(CFG_OFFSET, 32'(offset_picks[$urandom_range(0, 3)]));
    else cfg_write(CFG_OFFSET, $urandom & 32'hFFFF);
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SCALE, scale_picks[$urandom_range(0, 4)]);
    else cfg_write(CFG_SCALE, $urandom);
    cfg_write(CFG_ADDRESS, $urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (r < 45) cfg_write(CFG_MODE, 32'(MODE_A));
    else if (r < 90) cfg_write(CFG_MODE, 32'(MODE_B));
    else if (r < 95) cfg_write(CFG_MODE, 32'(MODE_OFF));
    else cfg_write(CFG_MODE, 32'(MODE_INERT));
  endtask

  function automatic item_t random_item();
    int unsigned r;
    logic [31:0] uptime;
    logic [47:0] bytes;
    logic [1:0] kind;
    r = $urandom_range(0, 99);
    if (r < 55) kind = KIND_TICK;
    else if (r < 80) kind = KIND_READ;
    else if (r < 92) kind = KIND_ERROR;
    else kind = KindUnused;
    r = $urandom_range(0, 99);
    if (r < 70) uptime = $urandom_range(10, 5000);
    else if (r < 85) uptime = $urandom_range(0, 9);
    else uptime = $urandom;
    r = $urandom_range(0, 19);
    if (r == 0) bytes = '0;
    else if (r == 1) bytes = '1;
    else bytes = 48'({$urandom, $urandom});
    return item_of(kind, uptime, bytes);
  endfunction

  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      randomize_settings();
      steady_flow = ($urandom_range(0, 3) == 0);
      repeat (54) send_item(random_item());
      drain();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    reset_decoder_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled_after_reset();
    test_startup_holdoff();
    test_decode_type_a();
    test_decode_type_b();
    test_lowered_interval();
    test_inert_mode();
    test_disabled_clears_valid();
    test_random_traffic();
    drain();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
